[hdl/truehd_access_unit_framer_top_assert.svh]
// Assertion macros of the access unit framer, used by thd_auf_core.
// Needs nothing else; each macro expands to one concurrent assertion.
`ifndef TRUEHD_ACCESS_UNIT_FRAMER_TOP_ASSERT_SVH
`define TRUEHD_ACCESS_UNIT_FRAMER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define THD_AUF_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("framer assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define THD_AUF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("framer assertion failed");

`endif

[hdl/thd_auf_pkg.sv]
// Types and constants of the access unit framer.
// Used by every module of the block; depends on nothing.
package thd_auf_pkg;

  localparam int unsigned WinDepth = 8;
  localparam int unsigned FillW    = 3;
  localparam int unsigned RemW     = 13;
  localparam int unsigned AddrW    = 3;

  localparam logic [31:0] SYNC_MASK     = 32'hFFFF_FFFE;
  localparam logic [31:0] SYNC_WORD     = 32'hF872_6FBA;
  localparam logic [3:0]  BAD_RUN_RESET = 4'd4;
  localparam logic [3:0]  BAD_RUN_MAX   = 4'd15;
  localparam logic [RemW-1:0] MIN_UNIT  = 13'd8;

  // Register index as seen on the configuration port (word address).
  localparam logic REG_MAX_BAD_RUN = 1'b0;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_REPORT = 2'd1,
    OP_RESET  = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] in_byte;
    logic       decode_failed;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        unit_first;
    logic        unit_last;
    logic [31:0] resync_count;
  } result_t;

endpackage

[hdl/thd_auf_regs.sv]
// Configuration register file of the access unit framer (APB-style port).
// Depends on thd_auf_pkg.
module thd_auf_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [thd_auf_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [3:0]                  max_bad_run_o
);
  import thd_auf_pkg::*;

  logic [3:0] max_bad_run_q;
  logic       wr_en;
  logic       sel_max;

  assign pready  = 1'b1;
  assign sel_max = (paddr[AddrW-1] == REG_MAX_BAD_RUN);
  assign wr_en   = psel && penable && pwrite && pready && sel_max;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bad_run_q <= BAD_RUN_RESET;
    end else if (wr_en) begin
      max_bad_run_q <= pwdata[3:0];
    end
  end

  assign prdata        = sel_max ? {28'd0, max_bad_run_q} : 32'd0;
  assign max_bad_run_o = max_bad_run_q;

endmodule

[hdl/thd_auf_core.sv]
// Framing state and single-cycle step logic: byte window, lock, unit length.
// Depends on thd_auf_pkg and the assertion macro header.
module thd_auf_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  thd_auf_pkg::item_t   item_i,
  input  logic [3:0]           max_bad_run_i,
  output logic                 res_valid_o,
  output thd_auf_pkg::result_t res_o
);
  import thd_auf_pkg::*;

  `include "truehd_access_unit_framer_top_assert.svh"

  logic [7:0]       win_q [WinDepth];
  logic [7:0]       win_d [WinDepth];
  logic [7:0]       win_new [WinDepth];
  logic [FillW-1:0] fill_q, fill_d;
  logic             locked_q, locked_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [3:0]       bad_q, bad_d;
  logic [31:0]      skip_q, skip_d;

  logic             full;
  logic             lock_kept;
  logic             sync_hit;
  logic [31:0]      sync_field;
  logic [RemW-1:0]  unit_len;
  logic [RemW-1:0]  rem_dec;

  // Window with the incoming byte dropped in at the fill position.
  always_comb begin
    for (int i = 0; i < WinDepth; i++) begin
      win_new[i] = (fill_q == FillW'(i)) ? item_i.in_byte : win_q[i];
    end
  end

  assign full       = (fill_q == FillW'(WinDepth - 1));
  assign sync_field = {win_new[4], win_new[5], win_new[6], win_new[7]};
  assign sync_hit   = ((sync_field & SYNC_MASK) == SYNC_WORD);
  assign unit_len   = {win_new[0][3:0], win_new[1], 1'b0};
  assign rem_dec    = rem_q - 13'd1;
  assign lock_kept  = locked_q && (bad_q < max_bad_run_i);

  always_comb begin
    win_d       = win_q;
    fill_d      = fill_q;
    locked_d    = locked_q;
    rem_d       = rem_q;
    bad_d       = bad_q;
    skip_d      = skip_q;
    res_valid_o = 1'b0;
    res_o.out_byte     = win_new[0];
    res_o.unit_first   = 1'b0;
    res_o.unit_last    = 1'b0;
    res_o.resync_count = skip_q;

    if (step_i) begin
      unique case (item_i.opcode)
        OP_REPORT: begin
          if (item_i.decode_failed) begin
            if (bad_q != BAD_RUN_MAX) bad_d = bad_q + 4'd1;
          end else begin
            bad_d = 4'd0;
          end
        end
        OP_RESET: begin
          fill_d   = '0;
          locked_d = 1'b0;
          rem_d    = '0;
        end
        OP_BYTE: begin
          if (!full) begin
            win_d  = win_new;
            fill_d = fill_q + FillW'(1);
          end else begin
            // Every full-window step retires the oldest byte, one way or another.
            for (int i = 0; i < WinDepth - 1; i++) begin
              win_d[i] = win_new[i+1];
            end
            win_d[WinDepth-1] = win_new[WinDepth-1];

            if (rem_q != '0) begin
              rem_d           = rem_dec;
              res_valid_o     = 1'b1;
              res_o.unit_last = (rem_dec == '0);
            end else begin
              if (locked_q && !lock_kept) bad_d = 4'd0;
              if (!lock_kept && !sync_hit) begin
                locked_d = 1'b0;
                skip_d   = skip_q + 32'd1;
              end else if (unit_len < MIN_UNIT) begin
                locked_d = 1'b0;
                skip_d   = skip_q + 32'd1;
              end else begin
                locked_d         = 1'b1;
                rem_d            = unit_len - 13'd1;
                res_valid_o      = 1'b1;
                res_o.unit_first = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      locked_q <= 1'b0;
      rem_q    <= '0;
      bad_q    <= '0;
      skip_q   <= '0;
    end else begin
      fill_q   <= fill_d;
      locked_q <= locked_d;
      rem_q    <= rem_d;
      bad_q    <= bad_d;
      skip_q   <= skip_d;
    end
  end

  `THD_AUF_ASSERT_IMPLIES(a_rem_needs_lock, clk_i, rst_ni, rem_q != '0, locked_q)
  `THD_AUF_ASSERT_IMPLIES(a_rem_needs_full, clk_i, rst_ni, rem_q != '0, full)
  `THD_AUF_ASSERT_NEXT(a_first_opens_unit, clk_i, rst_ni,
                       res_valid_o && res_o.unit_first, rem_q >= 13'd7)

endmodule

[hdl/thd_auf_outreg.sv]
// Result register of the access unit framer, with the downstream handshake.
// Depends on thd_auf_pkg.
module thd_auf_outreg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  input  thd_auf_pkg::result_t res_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output thd_auf_pkg::result_t res_o
);
  import thd_auf_pkg::*;

  logic    valid_q;
  result_t res_q;

  // The register may be reloaded when empty or when its word leaves now.
  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[hdl/truehd_access_unit_framer_top.sv]
// Access unit framer: takes one word per cycle (stream byte, decoder report or
// framing reset) and emits the bytes of each framed unit with first/last flags.
// A word is registered on acceptance and stepped through the framing logic once
// the result register is free, and any result it causes lands in the result
// register at the end of that step's cycle. A result thus passes the input
// register and then the result register before it is presented. One word is
// accepted every cycle unless the result register is full and stalled. A byte
// leaves the window, emitted or skipped, when the seventh stream byte after it
// arrives, since the window holds eight bytes.
// Depends on thd_auf_pkg, thd_auf_regs, thd_auf_core and thd_auf_outreg.
module truehd_access_unit_framer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic [7:0]                    in_byte_i,
  input  logic                          decode_failed_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic                          unit_first_o,
  output logic                          unit_last_o,
  output logic [31:0]                   resync_count_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [thd_auf_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import thd_auf_pkg::*;

  logic       in_valid_q;
  item_t      in_item_q;
  logic       out_free;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    out_res;
  logic [3:0] max_bad_run;

  assign in_stall_o = in_valid_q && !out_free;
  assign step       = in_valid_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q.opcode        <= opcode_i;
      in_item_q.in_byte       <= in_byte_i;
      in_item_q.decode_failed <= decode_failed_i;
    end
  end

  thd_auf_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .max_bad_run_o (max_bad_run)
  );

  thd_auf_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .item_i        (in_item_q),
    .max_bad_run_i (max_bad_run),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  thd_auf_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign out_byte_o     = out_res.out_byte;
  assign unit_first_o   = out_res.unit_first;
  assign unit_last_o    = out_res.unit_last;
  assign resync_count_o = out_res.resync_count;

endmodule
